// ----- rtl/ssba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssba_pkg;

    // bitmap word geometry
    localparam int WORD_BITS  = 64;
    localparam int WORD_OFS_W = 6;

    // field widths
    localparam int CFG_W   = 13;
    localparam int START_W = 12;

    localparam logic [CFG_W-1:0] SECTORS_RESET = 13'd4096;

    // request codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // result codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_MARK_HI,
        WR_MARK_LO,
        WR_REL_LO,
        WR_REL_HI
    } t_wr_kind;

    typedef struct packed {
        logic     start;
        logic     scan;
        logic     rd;
        logic     inc;
        t_wr_kind wr;
        logic     emit;
        logic     full;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_end;
        logic lo_needed;
        logic hi_needed;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/ssba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_action,
    input  wire logic          i_out_free,
    input  ssba_pkg::t_sts     i_sts,
    output logic               o_stall,
    output ssba_pkg::t_cmd     o_cmd
);
    import ssba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK_HI,
        S_MARK_LO,
        S_REL_RD_LO,
        S_REL_WR_LO,
        S_REL_RD_HI,
        S_REL_WR_HI,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_full, n_full;

    always_comb begin
        n_state   = r_state;
        n_full    = r_full;
        o_cmd     = '0;
        o_cmd.wr  = WR_NONE;
        o_cmd.full = r_full;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr  = WR_CLEAR;
                o_cmd.inc = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_full      = 1'b0;
                    n_state     = (i_action == ACT_ALLOC) ? S_SCAN : S_REL_RD_LO;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_MARK_HI;
                end else if (i_sts.scan_end) begin
                    n_full  = 1'b1;
                    n_state = S_FINISH;
                end
            end
            S_MARK_HI: begin
                o_cmd.wr = WR_MARK_HI;
                n_state  = i_sts.lo_needed ? S_MARK_LO : S_FINISH;
            end
            S_MARK_LO: begin
                o_cmd.wr = WR_MARK_LO;
                n_state  = S_FINISH;
            end
            S_REL_RD_LO: begin
                o_cmd.rd = 1'b1;
                n_state  = S_REL_WR_LO;
            end
            S_REL_WR_LO: begin
                o_cmd.wr  = WR_REL_LO;
                o_cmd.inc = 1'b1;
                n_state   = i_sts.hi_needed ? S_REL_RD_HI : S_FINISH;
            end
            S_REL_RD_HI: begin
                o_cmd.rd = 1'b1;
                n_state  = S_REL_WR_HI;
            end
            S_REL_WR_HI: begin
                o_cmd.wr = WR_REL_HI;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/ssba_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssba_dp #(
    parameter int NUM_SECTORS = 4096,
    parameter int RUN_LENGTH  = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  ssba_pkg::t_cmd                     i_cmd,
    input  wire logic                          i_action,
    input  wire logic [ssba_pkg::START_W-1:0]  i_run_start,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ssba_pkg::CFG_W-1:0]    i_cfg_wr_data,
    output ssba_pkg::t_sts                     o_sts,
    output logic [ssba_pkg::START_W-1:0]       o_start_sector
);
    import ssba_pkg::*;

    localparam int ROWS   = (NUM_SECTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int IW     = $clog2(ROWS + 1);
    localparam int AXW    = (IW > 7) ? IW : 7;
    localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW     = AXW + WORD_OFS_W;
    localparam int MASK_W = 2 * WORD_BITS;

    localparam logic [AXW-1:0]    ROWS_X   = AXW'(ROWS);
    localparam logic [CW-1:0]     NUM_X    = CW'(NUM_SECTORS);
    localparam logic [MASK_W-1:0] RUN_ONES =
        {{(MASK_W - RUN_LENGTH){1'b0}}, {RUN_LENGTH{1'b1}}};
    localparam logic [WORD_OFS_W:0] SHIFT_OFS = (WORD_OFS_W + 1)'(WORD_BITS + 1 - RUN_LENGTH);

    function automatic logic [WORD_OFS_W-1:0] f_lowest(input logic [WORD_BITS-1:0] v);
        logic [WORD_OFS_W-1:0] idx;
        idx = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = WORD_OFS_W'(k);
            end
        end
        return idx;
    endfunction

    logic [WORD_BITS-1:0] mem [ROWS];

    logic [CFG_W-1:0]     r_sectors_in_use;
    logic [AXW-1:0]       r_addr;
    logic [AXW-1:0]       r_eval_idx;
    logic                 r_rvalid;
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_prev_raw;
    logic [WORD_BITS-1:0] r_prev_free;
    logic [MASK_W-1:0]    r_mask;
    logic [CW-1:0]        r_hit_start;

    logic [CW-1:0]           w_cfg_ext, w_limit, w_base, w_rem;
    logic [WORD_OFS_W:0]     w_rem_clip;
    logic [WORD_BITS-1:0]    w_lim_mask, w_cur_free, w_hit_vec;
    logic [MASK_W-1:0]       w_window;
    logic [WORD_OFS_W-1:0]   w_hit_pos;
    logic                    w_end, w_hit, w_stop, w_advance;
    logic                    w_addr_ok;
    logic [MASK_W-1:0]       w_alloc_mask;
    logic [WORD_OFS_W:0]     w_shift;
    logic                    w_rd_en, w_wr_en;
    logic [AW-1:0]           w_rd_addr, w_wr_addr;
    logic [WORD_BITS-1:0]    w_wr_data;
    logic [AXW-1:0]          w_lo_idx;

    // sector count, saturated at the bitmap size
    assign w_cfg_ext = CW'(r_sectors_in_use);
    assign w_limit   = (w_cfg_ext > NUM_X) ? NUM_X : w_cfg_ext;
    assign w_base    = {r_eval_idx, {WORD_OFS_W{1'b0}}};
    assign w_rem     = w_limit - w_base;

    always_comb begin
        if (w_base >= w_limit) begin
            w_rem_clip = '0;
        end else if (w_rem >= CW'(WORD_BITS)) begin
            w_rem_clip = (WORD_OFS_W + 1)'(WORD_BITS);
        end else begin
            w_rem_clip = {1'b0, w_rem[WORD_OFS_W-1:0]};
        end
        for (int b = 0; b < WORD_BITS; b++) begin
            w_lim_mask[b] = ((WORD_OFS_W + 1)'(b) < w_rem_clip);
        end
    end

    assign w_cur_free = ~r_rdata & w_lim_mask;
    assign w_window   = {w_cur_free, r_prev_free};

    // a run ending at bit j of the current word, reaching back into the previous word
    for (genvar j = 0; j < WORD_BITS; j++) begin : g_win
        assign w_hit_vec[j] = &w_window[j + WORD_BITS -: RUN_LENGTH];
    end

    assign w_hit_pos    = f_lowest(w_hit_vec);
    assign w_end        = r_rvalid && (w_base >= w_limit);
    assign w_hit        = r_rvalid && !w_end && (|w_hit_vec);
    assign w_stop       = w_end || w_hit;
    assign w_advance    = i_cmd.scan && !w_stop;
    assign w_shift      = (WORD_OFS_W + 1)'(w_hit_pos) + SHIFT_OFS;
    assign w_alloc_mask = RUN_ONES << w_shift;
    assign w_addr_ok    = (r_addr < ROWS_X);
    assign w_lo_idx     = r_eval_idx - AXW'(1);

    assign w_rd_en   = (w_advance || i_cmd.rd) && w_addr_ok;
    assign w_rd_addr = r_addr[AW-1:0];

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_addr[AW-1:0];
        w_wr_data = '0;
        case (i_cmd.wr)
            WR_CLEAR: begin
                w_wr_en = w_addr_ok;
            end
            WR_MARK_HI: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_eval_idx[AW-1:0];
                w_wr_data = r_rdata | r_mask[MASK_W-1:WORD_BITS];
            end
            WR_MARK_LO: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_lo_idx[AW-1:0];
                w_wr_data = r_prev_raw | r_mask[WORD_BITS-1:0];
            end
            WR_REL_LO: begin
                w_wr_en   = w_addr_ok;
                w_wr_data = r_rdata & ~r_mask[WORD_BITS-1:0];
            end
            WR_REL_HI: begin
                w_wr_en   = w_addr_ok;
                w_wr_data = r_rdata & ~r_mask[MASK_W-1:WORD_BITS];
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sectors_in_use <= SECTORS_RESET;
            r_addr           <= '0;
            r_rvalid         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sectors_in_use <= i_cfg_wr_data;
            end
            r_rvalid <= w_advance;
            if (i_cmd.start) begin
                if (i_action == ACT_ALLOC) begin
                    r_addr <= '0;
                end else begin
                    r_addr <= AXW'(i_run_start[START_W-1:WORD_OFS_W]);
                end
            end else if (w_advance || i_cmd.inc) begin
                r_addr <= r_addr + AXW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hit_start <= '0;
            r_prev_free <= '0;
            r_prev_raw  <= '0;
            r_mask      <= RUN_ONES << i_run_start[WORD_OFS_W-1:0];
        end else begin
            if (w_advance) begin
                r_eval_idx <= r_addr;
                if (r_rvalid) begin
                    r_prev_free <= w_cur_free;
                    r_prev_raw  <= r_rdata;
                end
            end
            if (i_cmd.scan && w_hit) begin
                r_mask      <= w_alloc_mask;
                r_hit_start <= w_base + CW'(w_hit_pos) + CW'(1) - CW'(RUN_LENGTH);
            end
        end
    end

    assign o_sts.clr_last  = (r_addr == ROWS_X - AXW'(1));
    assign o_sts.scan_hit  = w_hit;
    assign o_sts.scan_end  = w_end;
    assign o_sts.lo_needed = |r_mask[WORD_BITS-1:0];
    assign o_sts.hi_needed = |r_mask[MASK_W-1:WORD_BITS];
    assign o_start_sector  = r_hit_start[START_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/swap_slot_bitmap_allocator.sv -----
// allocate: the scan reads the 64-sector words in turn (at most 64 at 4096 sectors)
// until a free run is found, then marks the word with its end and, when the run crosses
// a word boundary, the word before; release reads and clears the run's word, and the next
// on a crossing; one item at a time, next accept in the cycle after the result is emitted,
// the scan reading one bitmap word per cycle; a stalled result holds the block
// reset: synchronous, active low; a clearing pass (one word per cycle) stalls input
`timescale 1ns / 1ps
`default_nettype none

module swap_slot_bitmap_allocator #(
    parameter int NUM_SECTORS = 4096,
    parameter int RUN_LENGTH  = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_action,
    input  wire logic [ssba_pkg::START_W-1:0]  i_run_start,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ssba_pkg::START_W-1:0]       o_start_sector,
    output logic                               o_status,
    // sector count register
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ssba_pkg::CFG_W-1:0]    i_cfg_wr_data
);
    import ssba_pkg::*;

    t_cmd               w_cmd;
    t_sts               w_sts;
    logic               w_out_free;
    logic [START_W-1:0] w_dp_start;

    logic               r_out_valid;
    logic [START_W-1:0] r_out_start;
    logic               r_out_status;

    // output slot can take a new item when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_stall;

    // sequencer: clearing pass, scan, mark and release steps
    ssba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_action   (i_action),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd)
    );

    // bitmap memory, run window search and mask update
    ssba_dp #(
        .NUM_SECTORS (NUM_SECTORS),
        .RUN_LENGTH  (RUN_LENGTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_action       (i_action),
        .i_run_start    (i_run_start),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_sts          (w_sts),
        .o_start_sector (w_dp_start)
    );

    // result register, parts the result side from the request side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) begin
            r_out_start  <= w_cmd.full ? '0 : w_dp_start;
            r_out_status <= w_cmd.full ? STATUS_FULL : STATUS_DONE;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_start_sector = r_out_start;
    assign o_status       = r_out_status;

    // a full result never carries a start sector
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_FULL)) |-> (o_start_sector == '0))
        else $error("full result with nonzero start sector");

    // an accepted request blocks the next one while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request side not stalled after accept");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
